// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same as ASSERT_CLK with a caller-given message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== rtl/lnc_pkg.sv =====
// ----------------------------------------------------------------------------
// lnc_pkg
// Types, constants and helper functions of the Luhn number checker.
// ----------------------------------------------------------------------------
package lnc_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [4:0] LEN_IMEI  = 5'd15;
    localparam logic [4:0] LEN_CARD  = 5'd16;
    localparam logic [4:0] LEN_ICCID = 5'd20;
    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        STATUS_GOOD      = 2'd0,
        STATUS_BAD_SUM   = 2'd1,
        STATUS_BAD_CHAR  = 2'd2,
        STATUS_BAD_LEN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_IMEI  = 2'd1,
        KIND_CARD  = 2'd2,
        KIND_ICCID = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        status_t status;
        kind_t   number_kind;
    } verdict_item_t;

    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
    endfunction

    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] t;
        t = {d, 1'b0};
        return (t > 5'd9) ? 4'(t - 5'd9) : t[3:0];
    endfunction

endpackage

// ===== rtl/lnc_stream_if.sv =====
// ----------------------------------------------------------------------------
// lnc_stream_if
// Valid/ready stream channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface lnc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/luhn_number_checker.sv =====
// ----------------------------------------------------------------------------
// luhn_number_checker
// Luhn mod 10 check of IMEI, card and ICCID numbers given one character per item.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per cycle while its input is not held
// back, left to right, and gives one verdict for the item flagged as the last
// character, then starts over for the next identifier. A character is taken
// into an input register and from there updates the running sums in a single
// step; a verdict is formed from the input register and held in the result
// register. The result register and the input register let the character
// stream keep flowing while a verdict waits; only a verdict that waits with
// another last character right behind it holds the input back.
// ----------------------------------------------------------------------------
module luhn_number_checker (
    input  logic             clk,
    input  logic             rst_n,
    lnc_stream_if.sink       chars,
    lnc_stream_if.source     verdicts
);

    logic                       in_valid_reg;
    lnc_pkg::char_item_t        in_item_reg;
    logic                       out_valid_reg;
    lnc_pkg::verdict_item_t     out_item_reg;

    logic [3:0]                 sum_even_reg;
    logic [3:0]                 sum_odd_reg;
    logic [4:0]                 count_reg;
    logic                       bad_seen_reg;

    logic [3:0]                 sum_even_next;
    logic [3:0]                 sum_odd_next;
    logic [4:0]                 count_next;
    logic                       bad_seen_next;
    lnc_pkg::verdict_item_t     verdict_next;

    logic                       is_digit;
    logic [3:0]                 digit;
    logic [3:0]                 digit_dbl;
    logic [3:0]                 sel_sum;
    logic                       advance;
    logic                       in_take;

    assign advance = in_valid_reg
                     && (!in_item_reg.last_char || !out_valid_reg || verdicts.ready);
    assign chars.ready = !in_valid_reg || advance;
    assign in_take = chars.valid && chars.ready;

    assign verdicts.valid   = out_valid_reg;
    assign verdicts.payload = out_item_reg;

    always_comb
    begin
        is_digit  = (in_item_reg.character >= lnc_pkg::CHAR_ZERO)
                    && (in_item_reg.character <= lnc_pkg::CHAR_NINE);
        digit     = 4'(in_item_reg.character - lnc_pkg::CHAR_ZERO);
        digit_dbl = lnc_pkg::luhn_double(digit);

        sum_even_next = sum_even_reg;
        sum_odd_next  = sum_odd_reg;
        bad_seen_next = bad_seen_reg;
        if (is_digit)
        begin
            if (!count_reg[0])
            begin
                sum_even_next = lnc_pkg::add_mod10(sum_even_reg, digit_dbl);
                sum_odd_next  = lnc_pkg::add_mod10(sum_odd_reg, digit);
            end
            else
            begin
                sum_even_next = lnc_pkg::add_mod10(sum_even_reg, digit);
                sum_odd_next  = lnc_pkg::add_mod10(sum_odd_reg, digit_dbl);
            end
        end
        else
        begin
            bad_seen_next = 1'b1;
        end
        count_next = (count_reg < lnc_pkg::COUNT_MAX) ? count_reg + 5'd1 : count_reg;

        sel_sum = count_next[0] ? sum_odd_next : sum_even_next;
        verdict_next.number_kind = lnc_pkg::KIND_NONE;
        if (bad_seen_next)
        begin
            verdict_next.status = lnc_pkg::STATUS_BAD_CHAR;
        end
        else if (count_next == lnc_pkg::LEN_IMEI || count_next == lnc_pkg::LEN_CARD
                 || count_next == lnc_pkg::LEN_ICCID)
        begin
            verdict_next.status = (sel_sum == 4'd0) ? lnc_pkg::STATUS_GOOD
                                                    : lnc_pkg::STATUS_BAD_SUM;
            if (count_next == lnc_pkg::LEN_IMEI)
            begin
                verdict_next.number_kind = lnc_pkg::KIND_IMEI;
            end
            else if (count_next == lnc_pkg::LEN_CARD)
            begin
                verdict_next.number_kind = lnc_pkg::KIND_CARD;
            end
            else
            begin
                verdict_next.number_kind = lnc_pkg::KIND_ICCID;
            end
        end
        else
        begin
            verdict_next.status = lnc_pkg::STATUS_BAD_LEN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_even_reg  <= '0;
            sum_odd_reg   <= '0;
            count_reg     <= '0;
            bad_seen_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && in_item_reg.last_char)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdicts.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                if (in_item_reg.last_char)
                begin
                    sum_even_reg <= '0;
                    sum_odd_reg  <= '0;
                    count_reg    <= '0;
                    bad_seen_reg <= 1'b0;
                end
                else
                begin
                    sum_even_reg <= sum_even_next;
                    sum_odd_reg  <= sum_odd_next;
                    count_reg    <= count_next;
                    bad_seen_reg <= bad_seen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= chars.payload;
        end
        if (advance && in_item_reg.last_char)
        begin
            out_item_reg <= verdict_next;
        end
    end

endmodule

// ===== rtl/lnc_checker.sv =====
// ----------------------------------------------------------------------------
// lnc_checker
// Port-level assertions for the Luhn number checker, bound to luhn_number_checker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lnc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_payload
);

    logic [1:0] status;
    logic [1:0] kind;

    assign status = out_payload[3:2];
    assign kind   = out_payload[1:0];

    `ASSERT_CLK(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_payload))
    `ASSERT_CLK(a_err_kind, clk, rst_n, out_valid && (status == lnc_pkg::STATUS_BAD_CHAR || status == lnc_pkg::STATUS_BAD_LEN) |-> kind == lnc_pkg::KIND_NONE)
    `ASSERT_CLK(a_sum_kind, clk, rst_n, out_valid && (status == lnc_pkg::STATUS_GOOD || status == lnc_pkg::STATUS_BAD_SUM) |-> kind != lnc_pkg::KIND_NONE)
    `ASSERT_CLK_MSG(a_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2), "verdict without a last character")

endmodule

bind luhn_number_checker lnc_checker u_lnc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (chars.valid),
    .in_ready    (chars.ready),
    .in_last     (chars.payload.last_char),
    .out_valid   (verdicts.valid),
    .out_ready   (verdicts.ready),
    .out_payload (verdicts.payload)
);
